### rtl/core/ssph_pkg.sv
// ============================================================================
// ssph_pkg: shared types and constants for the six-step position hold core
// Field widths, register indexes, command codes and the control bundles that
// pass between the controller and the datapath.
// ============================================================================
`default_nettype none

package ssph_pkg;

    // Motor and field widths
    localparam int POLE_PAIRS  = 7;
    localparam int ENC_W       = 16;
    localparam int CMD_W       = 8;
    localparam int DUTY_W      = 7;
    localparam int POS_W       = 32;
    localparam int OFFS_W      = 9;
    localparam int HOLD_W      = 17;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 56;

    // Configuration port
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 17;
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_UPPER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_LOWER = 2'd2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_STANDBY  = 8'd0;
    localparam logic [CMD_W-1:0] CMD_HOLD_MAX = 8'd8;
    localparam logic [CMD_W-1:0] CMD_OPEN     = 8'd9;

    // Filter sum and the serial divide-by-100 unit (one nibble per step)
    localparam int SUM_W       = 40;
    localparam int DIV_STEPS   = SUM_W / 4;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    // Strobes from the controller, one per datapath step
    typedef struct packed {
        logic load;     // capture the accepted request
        logic scale;    // encoder word to scaled product, 99 * smoothed
        logic angle;    // angle mod 36000, angle / 100 product
        logic wrap;     // turn accumulator, biased electrical angle
        logic sum;      // filter sum, mod 360 product
        logic elec;     // electrical angle, start divider
        logic filt;     // saturate the filtered position
        logic cmp;      // deadband tests and sectors
        logic mag;      // deadband distance / 100 product
        logic commit;   // update state and load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic div_done; // divider quotient is final
        logic out_free; // result register can take a new result
    } t_dp_status;

endpackage

`default_nettype wire

### rtl/core/ssph_div100.sv
// ============================================================================
// ssph_div100: serial unsigned divide by 100
// Long division one hex digit per cycle; the digit comes from a small
// reciprocal multiply on the running remainder.
// ============================================================================
`default_nettype none

module ssph_div100 (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [ssph_pkg::SUM_W-1:0] i_num,
    output logic      [ssph_pkg::SUM_W-1:0] o_quo,
    output logic                            o_done
);
    import ssph_pkg::*;

    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [SUM_W-1:0]     r_num;
    logic [SUM_W-1:0]     r_quo;
    logic [6:0]           r_rem;

    logic [10:0]          w_x;
    logic [21:0]          w_prod;
    logic [3:0]           w_digit;
    logic [10:0]          w_sub;

    // Digit = x / 100 for x < 1600 via x * 1311 >> 17
    always_comb begin
        w_x     = {r_rem, r_num[SUM_W-1 -: 4]};
        w_prod  = 22'(w_x) * 22'd1311;
        w_digit = w_prod[20:17];
        w_sub   = w_x - 11'(w_digit) * 11'd100;
    end

    // Step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift in numerator digits, shift out quotient digits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_cnt != '0) begin
            r_num <= {r_num[SUM_W-5:0], 4'b0};
            r_rem <= w_sub[6:0];
            r_quo <= {r_quo[SUM_W-5:0], w_digit};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

`default_nettype wire

### rtl/core/ssph_ctrl.sv
// ============================================================================
// ssph_ctrl: sequencer for the position hold datapath
// Walks one request through the datapath steps and waits on the divider and
// on the result register.
// ============================================================================
`default_nettype none

module ssph_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire ssph_pkg::t_dp_status i_status,
    output ssph_pkg::t_dp_cmd         o_cmd
);
    import ssph_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCALE  = 4'd1;
    localparam logic [3:0] ST_ANGLE  = 4'd2;
    localparam logic [3:0] ST_WRAP   = 4'd3;
    localparam logic [3:0] ST_SUM    = 4'd4;
    localparam logic [3:0] ST_ELEC   = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_FILT   = 4'd7;
    localparam logic [3:0] ST_CMP    = 4'd8;
    localparam logic [3:0] ST_MAG    = 4'd9;
    localparam logic [3:0] ST_COMMIT = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // Next state and step strobes
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCALE;
                end
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = ST_ANGLE;
            end
            ST_ANGLE: begin
                o_cmd.angle = 1'b1;
                n_state     = ST_WRAP;
            end
            ST_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = ST_ELEC;
            end
            ST_ELEC: begin
                o_cmd.elec = 1'b1;
                n_state    = ST_DIV;
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                o_cmd.filt = 1'b1;
                n_state    = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state   = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.mag = 1'b1;
                n_state   = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

`default_nettype wire

### rtl/core/ssph_datapath.sv
// ============================================================================
// ssph_datapath: angle scaling, filter, hold logic and result register
// Holds the configuration, the motor state and the working registers that
// the controller steps through.
// ============================================================================
`default_nettype none

module ssph_datapath (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire ssph_pkg::t_dp_cmd               i_cmd,
    output ssph_pkg::t_dp_status                 o_status,
    input  wire logic [ssph_pkg::IN_TDATA_W-1:0] i_in_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [ssph_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [ssph_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [ssph_pkg::OUT_TDATA_W-1:0]     o_out_data
);
    import ssph_pkg::*;

    // Biased electrical angle: angle/100 * pole pairs + 720 - offset
    localparam int ELEC_BIAS = 720;
    localparam int ELEC_MAX  = 899 * POLE_PAIRS + ELEC_BIAS;
    localparam int ELEC_W    = $clog2(ELEC_MAX + 1);

    // Six-step sector from electrical angle plus a fixed lead
    function automatic logic [2:0] f_sector(input logic [8:0] e, input logic [8:0] lead);
        logic [9:0] v;
        logic [2:0] s;
        v = {1'b0, e} + {1'b0, lead};
        if (v >= 10'd360) begin
            v = v - 10'd360;
        end
        if (v < 10'd60) begin
            s = 3'd0;
        end else if (v < 10'd120) begin
            s = 3'd1;
        end else if (v < 10'd180) begin
            s = 3'd2;
        end else if (v < 10'd240) begin
            s = 3'd3;
        end else if (v < 10'd300) begin
            s = 3'd4;
        end else begin
            s = 3'd5;
        end
        return s;
    endfunction

    // Configuration registers
    logic [OFFS_W-1:0]        r_offset;
    logic [HOLD_W-1:0]        r_hold_up;
    logic [HOLD_W-1:0]        r_hold_lo;

    // Motor state
    logic [31:0]              r_acc;
    logic signed [POS_W-1:0]  r_smooth;
    logic [15:0]              r_prev;
    logic [2:0]               r_sector;
    logic [DUTY_W-1:0]        r_mag;
    logic                     r_en;

    // Working registers
    logic [ENC_W-1:0]         r_word;
    logic [CMD_W-1:0]         r_cmd;
    logic [27:0]              r_prod_a;
    logic signed [SUM_W-1:0]  r_mul99;
    logic [34:0]              r_prod_q;
    logic [15:0]              r_angle_m;
    logic [ELEC_W-1:0]        r_eraw;
    logic [ELEC_W+15:0]       r_prod_e;
    logic [8:0]               r_e;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_neg;
    logic signed [POS_W-1:0]  r_filt;
    logic                     r_up;
    logic                     r_lo;
    logic [32:0]              r_d;
    logic [2:0]               r_sec_up;
    logic [2:0]               r_sec_lo;
    logic                     r_big;
    logic [26:0]              r_prod_m;

    // Result register
    logic                     r_out_valid;
    logic [OUT_TDATA_W-1:0]   r_out_data;

    // Combinational helpers
    logic [17:0]              w_angle;
    logic [15:0]              w_angle_m;
    logic [31:0]              w_acc;
    logic [9:0]               w_q100;
    logic [SUM_W-1:0]         w_abs;
    logic [SUM_W-1:0]         w_quo;
    logic                     w_div_done;
    logic [ELEC_W-1:0]        w_q360;
    logic [ELEC_W-1:0]        w_e;
    logic signed [POS_W:0]    w_filt_x;
    logic [DUTY_W-1:0]        w_cap;
    logic [DUTY_W-1:0]        w_qm;
    logic [DUTY_W-1:0]        w_hmag;
    logic                     w_hold;
    logic [2:0]               n_sector;
    logic [DUTY_W-1:0]        n_mag;
    logic                     n_en;
    logic [DUTY_W-1:0]        w_du;
    logic [DUTY_W-1:0]        w_dv;
    logic [DUTY_W-1:0]        w_dw;

    // Angle in hundredths of a degree, reduced to one turn
    always_comb begin
        w_angle = r_prod_a[27:10];
        if (w_angle >= 18'd72000) begin
            w_angle_m = 16'(w_angle - 18'd72000);
        end else if (w_angle >= 18'd36000) begin
            w_angle_m = 16'(w_angle - 18'd36000);
        end else begin
            w_angle_m = w_angle[15:0];
        end
    end

    // Wrap detection on the reduced angle
    always_comb begin
        w_acc = r_acc;
        if (r_prev < 16'd9000 && r_angle_m > 16'd27000) begin
            w_acc = r_acc - 32'd36000;
        end else if (r_angle_m < 16'd9000 && r_prev > 16'd27000) begin
            w_acc = r_acc + 32'd36000;
        end
    end

    // Electrical angle: biased value minus quotient times 360
    always_comb begin
        w_q100 = r_prod_q[32:23];
        w_q360 = ELEC_W'(r_prod_e[ELEC_W+15:24]);
        w_e    = r_eraw - ELEC_W'(w_q360 * ELEC_W'(360));
    end

    // Magnitude of the filter sum for the divider
    assign w_abs = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);

    ssph_div100 u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.elec),
        .i_num   (w_abs),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    // Quotient with sign restored; the filter step saturates it to 32 bits
    always_comb begin
        w_filt_x = r_neg ? -$signed({1'b0, w_quo[POS_W-1:0]})
                         : $signed({1'b0, w_quo[POS_W-1:0]});
    end

    // Hold magnitude: deadband distance / 100, capped at command * 10
    always_comb begin
        w_cap  = DUTY_W'(r_cmd[3:0]) * DUTY_W'(10);
        w_qm   = r_prod_m[26:20];
        w_hold = (r_cmd != CMD_STANDBY) && (r_cmd <= CMD_HOLD_MAX);
        if (!(r_up || r_lo)) begin
            w_hmag = '0;
        end else if (r_big || (w_qm > w_cap)) begin
            w_hmag = w_cap;
        end else begin
            w_hmag = w_qm;
        end
    end

    // Next sector, magnitude and enable by command
    always_comb begin
        n_sector = r_sector;
        n_mag    = r_mag;
        n_en     = r_en;
        if (r_cmd == CMD_STANDBY) begin
            n_en = 1'b0;
        end else if (w_hold) begin
            n_en  = 1'b1;
            n_mag = w_hmag;
            if (r_up) begin
                n_sector = r_sec_up;
            end else if (r_lo) begin
                n_sector = r_sec_lo;
            end
        end else if (r_cmd == CMD_OPEN) begin
            n_en     = 1'b1;
            n_sector = r_sec_lo;
        end
    end

    // Six-step phase table
    always_comb begin
        w_du = '0;
        w_dv = '0;
        w_dw = '0;
        case (n_sector)
            3'd0: begin
                w_du = n_mag;
            end
            3'd1: begin
                w_du = n_mag;
                w_dv = n_mag;
            end
            3'd2: begin
                w_dv = n_mag;
            end
            3'd3: begin
                w_dv = n_mag;
                w_dw = n_mag;
            end
            3'd4: begin
                w_dw = n_mag;
            end
            3'd5: begin
                w_du = n_mag;
                w_dw = n_mag;
            end
            default: begin
                w_du = '0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset  <= '0;
            r_hold_up <= HOLD_W'(36500);
            r_hold_lo <= HOLD_W'(35500);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_OFFSET:     r_offset  <= i_cfg_data[OFFS_W-1:0];
                CFG_HOLD_UPPER: r_hold_up <= i_cfg_data[HOLD_W-1:0];
                CFG_HOLD_LOWER: r_hold_lo <= i_cfg_data[HOLD_W-1:0];
                default: begin
                    r_offset <= r_offset;
                end
            endcase
        end
    end

    // Motor state: advance on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_smooth <= '0;
            r_prev   <= '0;
            r_sector <= '0;
            r_mag    <= DUTY_W'(20);
            r_en     <= 1'b1;
        end else if (i_cmd.commit) begin
            r_acc    <= w_acc;
            r_smooth <= r_filt;
            r_prev   <= r_angle_m;
            r_sector <= n_sector;
            r_mag    <= n_mag;
            r_en     <= n_en;
        end
    end

    // Working registers, one group per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word <= i_in_data[ENC_W-1:0];
            r_cmd  <= i_in_data[ENC_W +: CMD_W];
        end
        if (i_cmd.scale) begin
            r_prod_a <= 28'({1'b0, r_word} + 17'd16384) * 28'd1125;
            r_mul99  <= SUM_W'(r_smooth) * SUM_W'(99);
        end
        if (i_cmd.angle) begin
            r_angle_m <= w_angle_m;
            r_prod_q  <= 35'(w_angle) * 35'd83887;
        end
        if (i_cmd.wrap) begin
            r_eraw <= ELEC_W'(w_q100) * ELEC_W'(POLE_PAIRS) + ELEC_W'(ELEC_BIAS)
                      - ELEC_W'(r_offset);
        end
        if (i_cmd.sum) begin
            r_sum    <= r_mul99 + $signed({24'b0, r_angle_m})
                        + SUM_W'($signed(w_acc));
            r_prod_e <= (ELEC_W+16)'(r_eraw) * (ELEC_W+16)'(46604);
        end
        if (i_cmd.elec) begin
            r_e   <= w_e[8:0];
            r_neg <= r_sum[SUM_W-1];
        end
        if (i_cmd.filt) begin
            if (!r_neg && (w_quo > SUM_W'(32'h7FFF_FFFF))) begin
                r_filt <= 32'sh7FFF_FFFF;
            end else if (r_neg && (w_quo > SUM_W'(33'h0_8000_0000))) begin
                r_filt <= 32'sh8000_0000;
            end else begin
                r_filt <= w_filt_x[POS_W-1:0];
            end
        end
        if (i_cmd.cmp) begin
            r_up     <= r_filt > $signed({15'b0, r_hold_up});
            r_lo     <= r_filt < $signed({15'b0, r_hold_lo});
            r_sec_up <= f_sector(r_e, 9'd300);
            r_sec_lo <= f_sector(r_e, 9'd120);
            if (r_filt > $signed({15'b0, r_hold_up})) begin
                r_d <= 33'($signed({r_filt[POS_W-1], r_filt}) - $signed({16'b0, r_hold_up}));
            end else begin
                r_d <= 33'($signed({16'b0, r_hold_lo}) - $signed({r_filt[POS_W-1], r_filt}));
            end
        end
        if (i_cmd.mag) begin
            r_big    <= r_d >= 33'd8100;
            r_prod_m <= 27'(r_d[12:0]) * 27'd10486;
        end
    end

    // Result register: load on commit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {2'b0, r_filt, n_en, w_dw, w_dv, w_du};
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

`default_nettype wire

### rtl/core/sensored_six_step_position_hold_core.sv
// ============================================================================
// sensored_six_step_position_hold_core: encoder-driven six-step position hold
// Scales each encoder sample to an angle, tracks turns, low-pass filters the
// position and drives three phase duties from a six-step table.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  encoder word, command
//   m_axis    out  m_axis_tvalid / m_axis_tready  duties, enable, position
//   cfg       in   i_cfg_valid / o_cfg_ready      register index, value
//
// A request runs through the scale, angle, wrap, sum, electrical, divide,
// filter, compare, magnitude and commit steps, and the next request is taken
// only once the core is back in idle; the serial divide-by-100 of the filter
// sum (one hex digit per step) is the longest part. A stalled result holds
// in the output register while the next request runs; commit waits until
// that register is free. Reset is synchronous and needs no clearing pass.
// Configuration is always ready.
// ============================================================================
`default_nettype none

module sensored_six_step_position_hold_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [15:0] encoder_word, [23:16] command
    input  wire logic [ssph_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [6:0] duty_u, [13:7] duty_v, [20:14] duty_w, [21] drive_enable,
    // [53:22] filtered_position, [55:54] zero
    output logic      [ssph_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ssph_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [ssph_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ssph_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    assign o_cfg_ready = 1'b1;

    ssph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ssph_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    // One request in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // Six-step output never drives all three phases
    a_six_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] == 7'd0 || m_axis_tdata[13:7] == 7'd0
                           || m_axis_tdata[20:14] == 7'd0))
        else $error("all three phases driven");

    // A new result appears only after a commit
    a_result_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.commit))
        else $error("result without commit");

    // Commit never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result overwritten");

endmodule

`default_nettype wire

### tb/ssph_drive_checker.sv
// ============================================================================
// ssph_drive_checker: result checker for the six-step position hold core
// Watches the configuration and sample channels, keeps its own copy of the
// angle tracking, turn count, position filter and six-step drive state, and
// compares every accepted result with the oldest predicted one.
// ============================================================================
`timescale 1ns / 1ps

module ssph_drive_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    input  wire logic                             s_axis_tready,
    // [15:0] encoder_word, [23:16] command
    input  wire logic [ssph_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [6:0] duty_u, [13:7] duty_v, [20:14] duty_w, [21] drive_enable,
    // [53:22] filtered_position, [55:54] zero
    input  wire logic [ssph_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                             i_cfg_valid,
    input  wire logic                             o_cfg_ready,
    input  wire logic [ssph_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [ssph_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                                    o_pending,
    output int                                    o_fail_count
);
    import ssph_pkg::*;

    localparam longint ANGLE_BIAS   = 16384;
    localparam longint CENTI_TURN   = 36000;
    localparam longint ENC_SPAN     = 32768;
    localparam longint WRAP_LOW     = 9000;
    localparam longint WRAP_HIGH    = 27000;
    localparam longint LEAD_SHIFT   = 300;
    localparam longint LAG_SHIFT    = 120;
    localparam longint FILTER_KEEP  = 99;
    localparam longint FILTER_DIV   = 100;
    localparam longint POS_MAX      = 64'sd2147483647;
    localparam longint POS_MIN      = -64'sd2147483648;
    localparam logic [HOLD_W-1:0] UPPER_AT_RESET = 17'd36500;
    localparam logic [HOLD_W-1:0] LOWER_AT_RESET = 17'd35500;
    localparam logic [DUTY_W-1:0] MAG_AT_RESET   = 7'd20;

    // Fields listed from the top bit down so duty_u lands in bit 0
    typedef struct packed {
        logic signed [POS_W-1:0] filtered_position;
        logic                    drive_enable;
        logic [DUTY_W-1:0]       duty_w;
        logic [DUTY_W-1:0]       duty_v;
        logic [DUTY_W-1:0]       duty_u;
    } t_phase_drive;

    // Register copies
    logic [OFFS_W-1:0]       offset_deg;
    logic [HOLD_W-1:0]       band_upper;
    logic [HOLD_W-1:0]       band_lower;

    // Motor state copies
    logic [31:0]             turn_count;
    logic signed [POS_W-1:0] smooth_pos;
    logic [15:0]             last_angle;
    logic [2:0]              cur_sector;
    logic [DUTY_W-1:0]       cur_mag;
    logic                    drive_on;

    t_phase_drive            expected_drive_q[$];
    int                      fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic logic [2:0] sector_from(input longint elec, input longint shift);
        return 3'(((elec + shift) % 360) / 60);
    endfunction

    // Advance the motor state by one sample and form the drive it produces
    function automatic t_phase_drive step_position(input logic [ENC_W-1:0] enc,
                                                   input logic [CMD_W-1:0] cmd);
        longint       angle;
        longint       elec;
        longint       total;
        longint       filt;
        longint       mag;
        t_phase_drive drive;
        angle = ((longint'(enc) + ANGLE_BIAS) * CENTI_TURN) / ENC_SPAN;
        elec  = (angle / 100) * POLE_PAIRS - longint'(offset_deg);
        elec  = elec % 360;
        if (elec < 0)
            elec = elec + 360;
        angle = angle % CENTI_TURN;

        // Count turns on a jump across the zero crossing
        if (longint'(last_angle) < WRAP_LOW && angle > WRAP_HIGH)
            turn_count = turn_count - 32'(CENTI_TURN);
        else if (angle < WRAP_LOW && longint'(last_angle) > WRAP_HIGH)
            turn_count = turn_count + 32'(CENTI_TURN);

        // Low-pass the continuous position, saturating to 32 bits
        total = FILTER_KEEP * longint'(smooth_pos) + angle + longint'($signed(turn_count));
        filt  = total / FILTER_DIV;
        if (filt > POS_MAX)
            filt = POS_MAX;
        if (filt < POS_MIN)
            filt = POS_MIN;
        smooth_pos = 32'(filt);

        if (cmd == CMD_STANDBY) begin
            drive_on = 1'b0;
        end else if (cmd <= CMD_HOLD_MAX) begin
            drive_on = 1'b1;
            // Upper edge is tested first, so an inverted band favors it
            if (filt > longint'(band_upper)) begin
                cur_sector = sector_from(elec, LEAD_SHIFT);
                mag = (filt - longint'(band_upper)) / 100;
            end else if (filt < longint'(band_lower)) begin
                cur_sector = sector_from(elec, LAG_SHIFT);
                mag = (longint'(band_lower) - filt) / 100;
            end else begin
                mag = 0;
            end
            if (mag > longint'(cmd) * 10)
                mag = longint'(cmd) * 10;
            cur_mag = DUTY_W'(mag);
        end else if (cmd == CMD_OPEN) begin
            drive_on = 1'b1;
            cur_sector = sector_from(elec, LAG_SHIFT);
        end
        last_angle = 16'(angle);

        // Six-step table
        drive = '0;
        case (cur_sector)
            3'd0: drive.duty_u = cur_mag;
            3'd1: begin
                drive.duty_u = cur_mag;
                drive.duty_v = cur_mag;
            end
            3'd2: drive.duty_v = cur_mag;
            3'd3: begin
                drive.duty_v = cur_mag;
                drive.duty_w = cur_mag;
            end
            3'd4: drive.duty_w = cur_mag;
            3'd5: begin
                drive.duty_u = cur_mag;
                drive.duty_w = cur_mag;
            end
            default: ;
        endcase
        drive.drive_enable      = drive_on;
        drive.filtered_position = smooth_pos;
        return drive;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    // Track requests, predict and compare
    always @(posedge i_clk) begin
        t_phase_drive got;
        t_phase_drive want;
        if (!i_rst_n) begin
            offset_deg = '0;
            band_upper = UPPER_AT_RESET;
            band_lower = LOWER_AT_RESET;
            turn_count = '0;
            smooth_pos = '0;
            last_angle = '0;
            cur_sector = '0;
            cur_mag    = MAG_AT_RESET;
            drive_on   = 1'b1;
            expected_drive_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    CFG_OFFSET:     offset_deg = i_cfg_data[OFFS_W-1:0];
                    CFG_HOLD_UPPER: band_upper = i_cfg_data[HOLD_W-1:0];
                    CFG_HOLD_LOWER: band_lower = i_cfg_data[HOLD_W-1:0];
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready) begin
                got = t_phase_drive'(m_axis_tdata[$bits(t_phase_drive)-1:0]);
                if (expected_drive_q.size() == 0) begin
                    $error("unexpected result: duty_u %0d duty_v %0d duty_w %0d",
                           got.duty_u, got.duty_v, got.duty_w);
                    fail_total++;
                end else begin
                    want = expected_drive_q.pop_front();
                    check_field("duty_u", want.duty_u, got.duty_u);
                    check_field("duty_v", want.duty_v, got.duty_v);
                    check_field("duty_w", want.duty_w, got.duty_w);
                    check_field("drive_enable", want.drive_enable, got.drive_enable);
                    check_field("filtered_position", want.filtered_position,
                                got.filtered_position);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_drive_q.push_back(step_position(s_axis_tdata[ENC_W-1:0],
                                                         s_axis_tdata[ENC_W +: CMD_W]));
        end
        o_pending <= expected_drive_q.size();
    end

endmodule

### tb/tb_sensored_six_step_position_hold_core.sv
// ============================================================================
// tb_sensored_six_step_position_hold_core: position hold core testbench
// Drives encoder samples and commands through the core under several register
// settings and idle patterns; a separate checker predicts and compares.
// ============================================================================
`timescale 1ns / 1ps

module tb_sensored_six_step_position_hold_core;
    import ssph_pkg::*;

    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_ITEMS    = 200;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 30;

    localparam logic [CMD_W-1:0]      CMD_HOLD_MIN     = 8'd1;
    localparam logic [CMD_W-1:0]      CMD_UNKNOWN_LOW  = 8'd10;
    localparam logic [CMD_W-1:0]      CMD_UNKNOWN_HIGH = 8'd255;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED       = 2'd3;

    // Encoder words at about 350.00 deg and 0.99 deg
    localparam logic [ENC_W-1:0] ENC_BEFORE_ZERO = 16'd15474;
    localparam logic [ENC_W-1:0] ENC_PAST_ZERO   = 16'd16475;
    localparam logic [ENC_W-1:0] ENC_HIGH_ANGLE  = 16'd12000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int                     pending_results;
    int                     fail_count;
    int                     stuck_cycles = 0;
    t_idle_mode             idle_mode = IDLE_NONE;
    logic [ENC_W-1:0]       track_word = '0;

    sensored_six_step_position_hold_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    ssph_drive_checker position_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_pending     (pending_results),
        .o_fail_count  (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (idle_mode == IDLE_RECEIVER)
            m_axis_tready <= ($urandom_range(99) >= 58);
        else if (idle_mode == IDLE_BOTH)
            m_axis_tready <= ($urandom_range(99) >= 11);
        else
            m_axis_tready <= 1'b1;
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_sensored_six_step_position_hold_core failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic int sender_idle_pct();
        if (idle_mode == IDLE_SENDER)
            return 58;
        if (idle_mode == IDLE_BOTH)
            return 11;
        return 0;
    endfunction

    // Mostly hold commands, with open, standby and unknown codes mixed in
    function automatic logic [CMD_W-1:0] pick_command();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return CMD_W'($urandom_range(CMD_HOLD_MIN, CMD_HOLD_MAX));
        if (roll < 85)
            return CMD_OPEN;
        if (roll < 92)
            return CMD_STANDBY;
        return CMD_W'($urandom_range(CMD_UNKNOWN_LOW, CMD_UNKNOWN_HIGH));
    endfunction

    // Present one request, idling first at random; valid stays high afterwards
    task automatic send_sample(input logic [ENC_W-1:0] enc, input logic [CMD_W-1:0] cmd);
        while ($urandom_range(99) < sender_idle_pct()) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cmd, enc};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
    endtask

    // Hold off until every predicted result has come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
    endtask

    // Write all three registers back to back, optionally hitting the unused index
    task automatic write_registers(input logic [OFFS_W-1:0] offs,
                                   input logic [HOLD_W-1:0] upper,
                                   input logic [HOLD_W-1:0] lower,
                                   input bit poke_unused);
        logic [CFG_ADDR_W-1:0] addr_list[4];
        logic [CFG_DATA_W-1:0] data_list[4];
        int                    first;
        addr_list[0] = CFG_UNUSED;
        data_list[0] = CFG_DATA_W'($urandom);
        addr_list[1] = CFG_OFFSET;
        data_list[1] = CFG_DATA_W'(offs);
        addr_list[2] = CFG_HOLD_UPPER;
        data_list[2] = upper;
        addr_list[3] = CFG_HOLD_LOWER;
        data_list[3] = lower;
        first = poke_unused ? 0 : 1;
        for (int k = first; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= addr_list[k];
            i_cfg_data  <= data_list[k];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Field extremes, every command kind, turn wraps and the first-sample case
    task automatic run_directed();
        send_sample(ENC_HIGH_ANGLE, CMD_HOLD_MIN);
        send_sample('0, CMD_HOLD_MAX);
        send_sample('1, CMD_OPEN);
        send_sample(16'h5555, CMD_STANDBY);
        send_sample(16'hAAAA, CMD_UNKNOWN_LOW);
        send_sample(16'h1234, CMD_UNKNOWN_HIGH);
        send_sample(16'h4321, CMD_OPEN);
        send_sample(ENC_BEFORE_ZERO, CMD_HOLD_MAX);
        send_sample(ENC_PAST_ZERO, CMD_HOLD_MAX);
        send_sample(ENC_BEFORE_ZERO, CMD_OPEN);
        for (int c = CMD_HOLD_MIN; c <= CMD_HOLD_MAX; c++)
            send_sample(ENC_W'($urandom), CMD_W'(c));
    endtask

    // Mostly smooth shaft motion at several speeds, some raw noise
    task automatic run_random(input int count, input bit pause_midway);
        int issued;
        int seg;
        int step_max;
        bit paused;
        issued = 0;
        paused = 1'b0;
        while (issued < count) begin
            if ($urandom_range(99) < 80) begin
                seg = $urandom_range(10, 60);
                case ($urandom_range(2))
                    0:       step_max = 4;
                    1:       step_max = 200;
                    default: step_max = 4000;
                endcase
                for (int n = 0; n < seg; n++) begin
                    track_word = track_word + ENC_W'($urandom_range(2 * step_max) - step_max);
                    send_sample(track_word, pick_command());
                end
            end else begin
                seg = $urandom_range(1, 8);
                for (int n = 0; n < seg; n++)
                    send_sample(ENC_W'($urandom), CMD_W'($urandom));
            end
            issued += seg;
            if (pause_midway && !paused && issued >= count / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        logic [HOLD_W-1:0] base;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        drain_results();

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: write_registers(9'd359, 17'd131071, 17'd0, 1'b0);
                1: write_registers(9'd511, 17'd0, 17'd131071, 1'b1);
                2: write_registers(9'd0, 17'd36500, 17'd35500, 1'b0);
                3: begin
                    base = HOLD_W'($urandom_range(45000));
                    write_registers(OFFS_W'($urandom), base + HOLD_W'($urandom_range(4000)),
                                    base, 1'b0);
                end
                4: write_registers(OFFS_W'($urandom), HOLD_W'($urandom), HOLD_W'($urandom),
                                   1'b1);
                default: write_registers(OFFS_W'($urandom_range(359)),
                                         HOLD_W'($urandom_range(40000)),
                                         HOLD_W'($urandom_range(40000)), 1'b0);
            endcase
            idle_mode <= t_idle_mode'(phase % 4);
            @(posedge i_clk);
            run_random(PHASE_ITEMS, phase == 1);
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_sensored_six_step_position_hold_core passed");
        else
            $display("tb_sensored_six_step_position_hold_core failed");
        $finish;
    end

endmodule
